### rtl/spsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared widths, reset values and error codes for the space packet stream
// checker.
// ----------------------------------------------------------------------------
package spsc_pkg;

  localparam int SEQ_BITS   = 14;
  localparam int TIME_BITS  = 32;
  localparam int APID_BITS  = 11;
  localparam int PAGE_BITS  = 16;
  localparam int PROD_BITS  = 16;
  localparam int LEN_BITS   = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [LEN_BITS-1:0] MIN_HDR_LEN_RST = 16'd16;

  // register index within the config space (word address)
  localparam logic REG_FIRST_PAGE = 1'b0;
  localparam logic REG_MIN_HDR    = 1'b1;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_TYPE       = 4'd1,
    ERR_GROUPING   = 4'd2,
    ERR_FIRST_PAGE = 4'd3,
    ERR_PAGE_GAP   = 4'd4,
    ERR_APID       = 4'd5,
    ERR_PRODUCT    = 4'd6,
    ERR_SEQUENCE   = 4'd7,
    ERR_TIME       = 4'd8,
    ERR_PAGE_COUNT = 4'd9
  } err_code_t;

endpackage : spsc_pkg
`default_nettype wire

### rtl/space_packet_stream_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// space_packet_stream_checker
// Continuity checker for a stream of space packets: one packet's decoded
// header fields per transfer in, one verdict per transfer out.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  in_      | in_valid / in_stall     | decoded packet header fields
//  out_     | out_valid / out_stall   | forward, error flag/code, stream end
//  config   | APB (psel..pready)      | first page (0x0), min hdr length (0x4)
//
//  One packet per cycle sustained while out_stall is low; each input transfer
//  passes the input register, then the result register, to its result.
//  The stream state is updated by the single compare stage between the two.
//  rst_n is synchronous; all control and stream state is cleared.
//  out_stall holds the result register; the input register keeps taking
//  transfers as long as the result register can drain.
// ----------------------------------------------------------------------------
module space_packet_stream_checker
  import spsc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,

  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_end_of_stream,
  input  wire logic                    in_type_flag,
  input  wire logic                    in_first_flag,
  input  wire logic                    in_last_flag,
  input  wire logic [APID_BITS-1:0]    in_apid,
  input  wire logic [SEQ_BITS-1:0]     in_seq_count,
  input  wire logic [PAGE_BITS-1:0]    in_page_number,
  input  wire logic [PROD_BITS-1:0]    in_product_id,
  input  wire logic [TIME_BITS-1:0]    in_packet_time,
  input  wire logic [LEN_BITS-1:0]     in_packet_length,
  input  wire logic [PAGE_BITS-1:0]    in_header_page_count,

  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_forward,
  output logic                         out_error_flag,
  output logic [3:0]                   out_error_code,
  output logic                         out_stream_end,

  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [CFG_ADDR_W-1:0]   paddr,
  input  wire logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready
);

  // configuration
  logic [PAGE_BITS-1:0] start_page_r;
  logic [LEN_BITS-1:0]  min_hdr_len_r;

  // input register
  logic                 s1_valid_r;
  logic                 s1_eos_r;
  logic                 s1_type_r;
  logic                 s1_first_r;
  logic                 s1_last_r;
  logic [APID_BITS-1:0] s1_apid_r;
  logic [SEQ_BITS-1:0]  s1_seq_r;
  logic [PAGE_BITS-1:0] s1_page_r;
  logic [PROD_BITS-1:0] s1_prod_r;
  logic [TIME_BITS-1:0] s1_time_r;
  logic [LEN_BITS-1:0]  s1_len_r;
  logic [PAGE_BITS-1:0] s1_hpages_r;

  // stream state
  logic                 awaiting_first_r, awaiting_first_nxt;
  logic                 in_redundant_r,   in_redundant_nxt;
  logic                 error_seen_r,     error_seen_nxt;
  logic [PAGE_BITS-1:0] exp_pages_r,      exp_pages_nxt;
  logic [PAGE_BITS-1:0] prev_page_r;
  logic [APID_BITS-1:0] prev_apid_r;
  logic [PROD_BITS-1:0] prev_prod_r;
  logic [SEQ_BITS-1:0]  prev_seq_r;
  logic [TIME_BITS-1:0] prev_time_r;

  // result register
  logic                 out_valid_r;
  logic                 out_forward_r;
  logic                 out_error_flag_r;
  err_code_t            out_error_code_r;
  logic                 out_stream_end_r;

  logic                 out_free;
  logic                 s1_fire;
  logic                 cfg_wr;

  logic                 long_enough;
  logic signed [PAGE_BITS+1:0] span;
  logic                 span_match;
  logic                 hp_match;
  logic                 page_next_ok;
  logic                 open_redundant;
  logic                 record;
  logic                 fwd;
  logic                 stream_end;
  err_code_t            code;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_FIRST_PAGE: prdata = {{(CFG_DATA_W-PAGE_BITS){1'b0}}, start_page_r};
      REG_MIN_HDR:    prdata = {{(CFG_DATA_W-LEN_BITS){1'b0}}, min_hdr_len_r};
      default:        prdata = '0;
    endcase
  end

  // page span is exact: prev_page - start_page + 1, signed, no wrap
  assign long_enough  = s1_len_r >= min_hdr_len_r;
  assign span         = $signed({2'b00, prev_page_r}) - $signed({2'b00, start_page_r})
                        + $signed({{(PAGE_BITS+1){1'b0}}, 1'b1});
  assign span_match   = span == $signed({2'b00, exp_pages_r});
  assign hp_match     = span == $signed({2'b00, s1_hpages_r});
  assign page_next_ok = {1'b0, s1_page_r} == ({1'b0, prev_page_r} + 17'd1);
  assign open_redundant = !in_redundant_r && (s1_page_r == start_page_r) &&
                          (span_match || (exp_pages_r == '0));

  always_comb begin
    awaiting_first_nxt = awaiting_first_r;
    in_redundant_nxt   = in_redundant_r;
    exp_pages_nxt      = exp_pages_r;
    code               = ERR_NONE;
    record             = 1'b0;
    stream_end         = 1'b0;

    if (s1_eos_r) begin
      stream_end = 1'b1;
    end else if (error_seen_r) begin
      code = ERR_NONE;
    end else if (s1_type_r) begin
      code = ERR_TYPE;
    end else if (!s1_first_r || !s1_last_r) begin
      code = ERR_GROUPING;
    end else if (awaiting_first_r) begin
      // the first packet loads the page count, if it is long enough, even if its page is wrong
      awaiting_first_nxt = 1'b0;
      if (long_enough) begin
        exp_pages_nxt = s1_hpages_r;
      end
      if (s1_page_r != start_page_r) begin
        code = ERR_FIRST_PAGE;
      end else begin
        record = 1'b1;
      end
    end else begin
      if (open_redundant) begin
        in_redundant_nxt = 1'b1;
        if (long_enough && !hp_match) begin
          code = ERR_PAGE_COUNT;
        end
      end else if (!page_next_ok) begin
        code = ERR_PAGE_GAP;
      end

      if (code == ERR_NONE) begin
        if (s1_apid_r != prev_apid_r) begin
          code = ERR_APID;
        end else if (s1_prod_r != prev_prod_r) begin
          code = ERR_PRODUCT;
        end else if (s1_seq_r != prev_seq_r + {{(SEQ_BITS-1){1'b0}}, 1'b1}) begin
          code = ERR_SEQUENCE;
        end else if (s1_time_r < prev_time_r) begin
          code = ERR_TIME;
        end else begin
          record = 1'b1;
        end
      end
    end

    fwd            = record && !in_redundant_nxt;
    error_seen_nxt = error_seen_r || (code != ERR_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_page_r     <= '0;
      min_hdr_len_r    <= MIN_HDR_LEN_RST;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      awaiting_first_r <= 1'b1;
      in_redundant_r   <= 1'b0;
      error_seen_r     <= 1'b0;
      exp_pages_r      <= '0;
      prev_page_r      <= '0;
      prev_apid_r      <= '0;
      prev_prod_r      <= '0;
      prev_seq_r       <= '0;
      prev_time_r      <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_FIRST_PAGE: start_page_r  <= pwdata[PAGE_BITS-1:0];
          REG_MIN_HDR:    min_hdr_len_r <= pwdata[LEN_BITS-1:0];
          default:        start_page_r  <= start_page_r;
        endcase
      end

      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end

      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end

      if (s1_fire) begin
        awaiting_first_r <= awaiting_first_nxt;
        in_redundant_r   <= in_redundant_nxt;
        error_seen_r     <= error_seen_nxt;
        exp_pages_r      <= exp_pages_nxt;
        if (record) begin
          prev_page_r <= s1_page_r;
          prev_apid_r <= s1_apid_r;
          prev_prod_r <= s1_prod_r;
          prev_seq_r  <= s1_seq_r;
          prev_time_r <= s1_time_r;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_eos_r    <= in_end_of_stream;
      s1_type_r   <= in_type_flag;
      s1_first_r  <= in_first_flag;
      s1_last_r   <= in_last_flag;
      s1_apid_r   <= in_apid;
      s1_seq_r    <= in_seq_count;
      s1_page_r   <= in_page_number;
      s1_prod_r   <= in_product_id;
      s1_time_r   <= in_packet_time;
      s1_len_r    <= in_packet_length;
      s1_hpages_r <= in_header_page_count;
    end
    if (s1_fire) begin
      out_forward_r    <= fwd;
      out_error_flag_r <= error_seen_nxt;
      out_error_code_r <= code;
      out_stream_end_r <= stream_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_forward    = out_forward_r;
  assign out_error_flag = out_error_flag_r;
  assign out_error_code = out_error_code_r;
  assign out_stream_end = out_stream_end_r;

  // a new error code always comes with the sticky flag
  a_code_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != ERR_NONE) |-> out_error_flag)
    else $error("error code without error flag");

  // nothing forwarded once an error is flagged or on the end marker
  a_fwd_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_forward) |-> (!out_error_flag && !out_stream_end))
    else $error("forward with error or stream end");

  // the error state is sticky
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    error_seen_r |=> error_seen_r)
    else $error("error state cleared");

  // the redundant header opens only once and stays open
  a_redundant_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    in_redundant_r |=> in_redundant_r)
    else $error("redundant state cleared");

  // end marker carries no error code
  a_end_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stream_end) |-> (out_error_code == ERR_NONE))
    else $error("stream end with error code");

endmodule : space_packet_stream_checker
`default_nettype wire
